// ----- hdl/bdy_pkg.sv -----
// ----------------------------------------------------------------------------
// bdy_pkg
// shared types and constants of the buddy allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bdy_pkg;

   localparam int ADDR_W  = 48;
   localparam int BYTES_W = 13;
   localparam int ST_W    = 2;
   localparam int KW      = 5;
   localparam int NEED_W  = 17;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_OOM     = 2'd1;
   localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      logic              sub;
   } add_op_type;

endpackage

`default_nettype wire

// ----- hdl/buddy_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_allocator
// binary buddy allocator, free tree and live order table in rams
// ----------------------------------------------------------------------------
// allocate: order search, free tree scan (a read and a check per node), split
//   (one per level), then 3 address steps
// free: address and live table lookup, then a buddy read and check per coalesced level
// one request at a time: req_tready is high only in the idle state
// reset: a clearing pass writes every entry of both rams, no transfer
//   accepted meanwhile; heap_base resets to zero
`default_nettype none

module buddy_allocator
   import bdy_pkg::*;
#(
   parameter int HEAP_ORDER = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [47:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // request_bytes, align_log2, free_address, zero pad
   input  wire logic [0:0]  req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [63:0] rsp_tdata,   // address, block_bytes, zero pad
   output logic      [1:0]  rsp_tuser    // status
);

   localparam int NW         = HEAP_ORDER + 1;
   localparam int TREE_DEPTH = 2 << HEAP_ORDER;
   localparam int LIVE_DEPTH = 1 << HEAP_ORDER;
   localparam int LW         = $clog2(HEAP_ORDER + 2);
   localparam logic [ADDR_W-1:0] HEAP_SIZE = ADDR_W'(1) << HEAP_ORDER;
   localparam logic [KW-1:0]     HO_K      = KW'(HEAP_ORDER);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_KCALC    = 4'd2;
   localparam logic [3:0] S_SCAN_RD  = 4'd3;
   localparam logic [3:0] S_SCAN_CHK = 4'd4;
   localparam logic [3:0] S_SPLIT    = 4'd5;
   localparam logic [3:0] S_ADDR0    = 4'd6;
   localparam logic [3:0] S_ADDR1    = 4'd7;
   localparam logic [3:0] S_ADDR2    = 4'd8;
   localparam logic [3:0] S_FREL     = 4'd9;
   localparam logic [3:0] S_FCHK     = 4'd10;
   localparam logic [3:0] S_FBUD_RD  = 4'd11;
   localparam logic [3:0] S_FBUD_CHK = 4'd12;
   localparam logic [3:0] S_DONE     = 4'd13;

   logic [3:0]        state_ff, state_in;
   logic [NW-1:0]     cnt_ff, cnt_in;
   logic [ADDR_W-1:0] base_ff;
   logic              act_ff, act_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [14:0]       am1_ff, am1_in;
   logic [ADDR_W-1:0] faddr_ff, faddr_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [KW-1:0]     j_ff, j_in;
   logic [NW-1:0]     node_ff, node_in;
   logic [ADDR_W-1:0] acc_ff, acc_in;
   logic [ST_W-1:0]   st_ff, st_in;
   logic              rv_ff, rv_in;
   logic [ST_W-1:0]   rst_ff, rst_in;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   logic [BYTES_W-1:0] rbytes_ff, rbytes_in;

   logic              tree_we, tree_wd, tree_rd;
   logic [NW-1:0]     tree_wa, tree_ra;
   logic              live_we;
   logic [LW-1:0]     live_wd, live_rd;
   logic [HEAP_ORDER-1:0] live_wa, live_ra;

   add_op_type        op;
   logic [ADDR_W-1:0] y;
   logic [NW:0]       n1;
   logic [NW-1:0]     top, buddy;
   logic [KW-1:0]     kv;
   logic [31:0]       bytes_full;
   logic [15:0]       am1_full;

   bdy_ram #(.WIDTH(1), .DEPTH(TREE_DEPTH)) u_tree (
      .clock(clock), .we(tree_we), .waddr(tree_wa), .wdata(tree_wd),
      .raddr(tree_ra), .rdata(tree_rd)
   );

   bdy_ram #(.WIDTH(LW), .DEPTH(LIVE_DEPTH)) u_live (
      .clock(clock), .we(live_we), .waddr(live_wa), .wdata(live_wd),
      .raddr(live_ra), .rdata(live_rd)
   );

   bdy_addr_unit u_add (.op(op), .y(y));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rst_ff;
   assign rsp_tdata  = {3'd0, rbytes_ff, raddr_ff};

   assign n1         = {1'b0, node_ff} + (NW+1)'(1);
   assign top        = NW'(1) << (HO_K - k_ff);
   assign buddy      = node_ff ^ NW'(1);
   assign kv         = KW'(live_rd) - KW'(1);
   assign bytes_full = 32'(1) << k_ff;
   assign am1_full   = (16'(1) << req_tdata[19:16]) - 16'd1;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      act_in    = act_ff;
      need_in   = need_ff;
      am1_in    = am1_ff;
      faddr_in  = faddr_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      node_in   = node_ff;
      acc_in    = acc_ff;
      st_in     = st_ff;
      rv_in     = rv_ff;
      rst_in    = rst_ff;
      raddr_in  = raddr_ff;
      rbytes_in = rbytes_ff;
      tree_we   = 1'b0;
      tree_wa   = node_ff;
      tree_wd   = 1'b0;
      tree_ra   = node_ff;
      live_we   = 1'b0;
      live_wa   = acc_ff[HEAP_ORDER-1:0];
      live_wd   = '0;
      live_ra   = y[HEAP_ORDER-1:0];
      op        = '{a: '0, b: '0, sub: 1'b0};

      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            tree_we = 1'b1;
            tree_wa = cnt_ff;
            tree_wd = (cnt_ff == NW'(1));
            live_we = 1'b1;
            live_wa = cnt_ff[HEAP_ORDER-1:0];
            cnt_in  = cnt_ff + NW'(1);
            if (cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               act_in   = req_tuser[0];
               need_in  = NEED_W'(req_tdata[15:0]) + NEED_W'(am1_full);
               am1_in   = am1_full[14:0];
               faddr_in = req_tdata[67:20];
               k_in     = '0;
               state_in = (req_tuser[0] == ACT_ALLOC) ? S_KCALC : S_FREL;
            end
         end
         S_KCALC: begin
            if ((18'(1) << k_ff) < 18'(need_ff)) begin
               k_in = k_ff + KW'(1);
            end else if (k_ff > HO_K) begin
               st_in    = ST_OOM;
               state_in = S_DONE;
            end else begin
               j_in     = k_ff;
               node_in  = NW'(1) << (HO_K - k_ff);
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (tree_rd) begin
               tree_we  = 1'b1;
               state_in = (j_ff > k_ff) ? S_SPLIT : S_ADDR0;
            end else if ((n1[NW-1:0] & node_ff) == '0) begin
               if (j_ff == HO_K) begin
                  st_in    = ST_OOM;
                  state_in = S_DONE;
               end else begin
                  j_in     = j_ff + KW'(1);
                  node_in  = NW'(n1[NW:2]);
                  state_in = S_SCAN_RD;
               end
            end else begin
               node_in  = n1[NW-1:0];
               state_in = S_SCAN_RD;
            end
         end
         S_SPLIT: begin
            tree_we = 1'b1;
            tree_wa = {node_ff[NW-2:0], 1'b1};
            tree_wd = 1'b1;
            node_in = {node_ff[NW-2:0], 1'b0};
            j_in    = j_ff - KW'(1);
            if (j_ff - KW'(1) == k_ff) begin
               state_in = S_ADDR0;
            end
         end
         S_ADDR0: begin
            op       = '{a: base_ff, b: ADDR_W'(node_ff & ~top) << k_ff, sub: 1'b0};
            acc_in   = y;
            state_in = S_ADDR1;
         end
         S_ADDR1: begin
            op       = '{a: acc_ff, b: ADDR_W'(am1_ff), sub: 1'b0};
            acc_in   = y & ~ADDR_W'(am1_ff);
            state_in = S_ADDR2;
         end
         S_ADDR2: begin
            op       = '{a: acc_ff, b: base_ff, sub: 1'b1};
            live_wa  = y[HEAP_ORDER-1:0];
            live_wd  = LW'(k_ff + KW'(1));
            live_we  = (y < HEAP_SIZE);
            st_in    = ST_OK;
            state_in = S_DONE;
         end
         S_FREL: begin
            op     = '{a: faddr_ff, b: base_ff, sub: 1'b1};
            acc_in = y;
            if (y >= HEAP_SIZE) begin
               st_in    = ST_UNKNOWN;
               state_in = S_DONE;
            end else begin
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (live_rd == '0 || KW'(live_rd) > KW'(HEAP_ORDER + 1)) begin
               st_in    = ST_UNKNOWN;
               state_in = S_DONE;
            end else begin
               k_in     = kv;
               live_we  = 1'b1;
               node_in  = (NW'(1) << (HO_K - kv)) | NW'(acc_ff[HEAP_ORDER-1:0] >> kv);
               state_in = S_FBUD_RD;
            end
         end
         S_FBUD_RD: begin
            tree_we = 1'b1;
            tree_ra = buddy;
            if (node_ff == NW'(1)) begin
               tree_wd  = 1'b1;
               st_in    = ST_OK;
               state_in = S_DONE;
            end else begin
               state_in = S_FBUD_CHK;
            end
         end
         S_FBUD_CHK: begin
            tree_we = 1'b1;
            if (tree_rd) begin
               tree_wa  = buddy;
               node_in  = node_ff >> 1;
               state_in = S_FBUD_RD;
            end else begin
               tree_wd  = 1'b1;
               st_in    = ST_OK;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in     = 1'b1;
               rst_in    = st_ff;
               raddr_in  = (st_ff == ST_OK && act_ff == ACT_ALLOC) ? acc_ff : '0;
               rbytes_in = (st_ff == ST_OK) ? bytes_full[BYTES_W-1:0] : '0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         base_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
      end
      act_ff    <= act_in;
      need_ff   <= need_in;
      am1_ff    <= am1_in;
      faddr_ff  <= faddr_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      node_ff   <= node_in;
      acc_ff    <= acc_in;
      st_ff     <= st_in;
      rst_ff    <= rst_in;
      raddr_ff  <= raddr_in;
      rbytes_ff <= rbytes_in;
   end

   a_split_above: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SPLIT |-> j_ff > k_ff)
      else $error("split below requested order");

   a_no_node0: assert property (@(posedge clock) disable iff (reset)
      (tree_we && state_ff != S_CLEAR) |-> tree_wa != '0)
      else $error("write to unused tree node");

   a_buddy_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FBUD_CHK |-> node_ff > NW'(1))
      else $error("buddy check at root");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rv_ff && !rsp_tready) |=> state_ff == S_DONE)
      else $error("result dropped while output busy");

endmodule

`default_nettype wire

// ----- hdl/bdy_ram.sv -----
// ----------------------------------------------------------------------------
// bdy_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bdy_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- hdl/bdy_addr_unit.sv -----
// ----------------------------------------------------------------------------
// bdy_addr_unit
// shared 48-bit address adder and subtractor
// ----------------------------------------------------------------------------
`default_nettype none

module bdy_addr_unit
   import bdy_pkg::*;
(
   input  wire add_op_type        op,
   output logic [ADDR_W-1:0]      y
);

   assign y = op.sub ? (op.a - op.b) : (op.a + op.b);

endmodule

`default_nettype wire

// ----- bench/tb_checker.sv -----
// ----------------------------------------------------------------------------
// tb_checker
// watches the request, response and csr ports of the buddy allocator, keeps
// its own free tree and live block table, predicts each response and
// compares it field by field against the observed transfer
// ----------------------------------------------------------------------------
`default_nettype none

module tb_checker
   import bdy_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [47:0] csr_wdata,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,
   input  wire logic [0:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ORD = 12;
   localparam logic [63:0] AMASK = (64'd1 << ADDR_W) - 1;

   typedef struct {
      logic [ST_W-1:0]    status;
      logic [ADDR_W-1:0]  address;
      logic [BYTES_W-1:0] block_bytes;
   } alloc_result_type;

   alloc_result_type result_q[$];
   bit            tree_free[2 << ORD];
   logic [4:0]    live_ord[1 << ORD];
   logic [63:0]   base;

   function automatic alloc_result_type predict_alloc(logic [15:0] req, logic [3:0] al);
      alloc_result_type r;
      logic [63:0] align, needed, off, addr, aligned, key;
      int k, j, node, first;
      bit found;
      align = 64'd1 << al;
      needed = {48'd0, req} + align - 1;
      k = 0;
      found = 0;
      node = 0;
      r = '{ST_OOM, '0, '0};
      while (k < 40 && (64'd1 << k) < needed) k++;
      if (k > ORD) return r;
      for (j = k; j <= ORD && !found; j++) begin
         first = 1 << (ORD - j);
         for (int i = 0; i < first; i++) begin
            if (tree_free[first + i]) begin
               node = first + i;
               found = 1;
               break;
            end
         end
      end
      if (!found) return r;
      j--;
      tree_free[node] = 0;
      while (j > k) begin
         tree_free[2 * node + 1] = 1;
         node = 2 * node;
         j--;
      end
      off = 64'(node - (1 << (ORD - k))) << k;
      addr = (base + off) & AMASK;
      aligned = ((addr + align - 1) & ~(align - 1)) & AMASK;
      key = (aligned - base) & AMASK;
      if (key < (64'd1 << ORD)) live_ord[key] = 5'(k + 1);
      r.status = ST_OK;
      r.address = aligned[ADDR_W-1:0];
      r.block_bytes = BYTES_W'(64'd1 << k);
      return r;
   endfunction

   function automatic alloc_result_type predict_free(logic [47:0] fa);
      alloc_result_type r;
      logic [63:0] rel, off;
      int k, node;
      r = '{ST_UNKNOWN, '0, '0};
      rel = ({16'd0, fa} - base) & AMASK;
      if (rel >= (64'd1 << ORD)) return r;
      if (live_ord[rel] == 0 || live_ord[rel] > ORD + 1) return r;
      k = live_ord[rel] - 1;
      live_ord[rel] = 0;
      off = rel & ~((64'd1 << k) - 1);
      node = (1 << (ORD - k)) + int'(off >> k);
      tree_free[node] = 1;
      while (node > 1 && tree_free[node ^ 1]) begin
         tree_free[node] = 0;
         tree_free[node ^ 1] = 0;
         node = node >> 1;
         tree_free[node] = 1;
      end
      r.status = ST_OK;
      r.block_bytes = BYTES_W'(64'd1 << k);
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type e;
      if (reset) begin
         base = 0;
         fail_count = 0;
         foreach (tree_free[i]) tree_free[i] = 0;
         foreach (live_ord[i]) live_ord[i] = 0;
         tree_free[1] = 1;
         result_q.delete();
      end else begin
         if (csr_we) base = {16'd0, csr_wdata};
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == ACT_ALLOC)
               result_q.insert(result_q.size(),
                               predict_alloc(req_tdata[15:0], req_tdata[19:16]));
            else
               result_q.insert(result_q.size(), predict_free(req_tdata[67:20]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response status %0d address %h bytes %0d", $time,
                        rsp_tuser, rsp_tdata[47:0], rsp_tdata[60:48]);
            end else begin
               e = result_q.pop_front();
               if (rsp_tuser !== e.status || rsp_tdata[47:0] !== e.address
                   || rsp_tdata[60:48] !== e.block_bytes) begin
                  fail_count++;
                  $display("%0t: expected status %0d address %h bytes %0d, got %0d %h %0d",
                           $time, e.status, e.address, e.block_bytes, rsp_tuser,
                           rsp_tdata[47:0], rsp_tdata[60:48]);
               end
            end
         end
      end
      pending <= result_q.size();
   end

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the buddy allocator: directed corner requests,
// then random allocate and free traffic over several heap bases and
// idle/stall phases, with a long response hold-off and a drain pause
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import bdy_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [47:0] AMAX = 48'hFFFF_FFFF_FFFF;
   localparam int WD_LIMIT = 200000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [47:0] csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   int          fail_count, pending;

   int          send_idle = 0, recv_stall = 0;
   int          holds_asked = 0, holds_done = 0, hold_left = 0;
   int          quiet = 0;
   logic [47:0] heap_base_now = '0;
   logic [47:0] live_offs[$];
   logic        sent_kind[$];

   always #2 clock = ~clock;

   buddy_allocator u_dut (.*);
   tb_checker u_chk (.*);

   always @(posedge clock) begin
      if (holds_done < holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left <= 3000;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // track live blocks as heap offsets from completed allocations
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sent_kind.insert(sent_kind.size(), req_tuser[0]);
         if (rsp_tvalid && rsp_tready && sent_kind.size() > 0) begin
            if (sent_kind.pop_front() == ACT_ALLOC && rsp_tuser == ST_OK)
               live_offs.insert(live_offs.size(), rsp_tdata[47:0] - heap_base_now);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WD_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send(logic act, logic [15:0] nbytes, logic [3:0] al, logic [47:0] fa);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {4'd0, fa, al, nbytes};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic alloc(logic [15:0] nbytes, logic [3:0] al);
      send(ACT_ALLOC, nbytes, al, 48'({$urandom, $urandom}));
   endtask

   task automatic free_addr(logic [47:0] fa);
      send(ACT_FREE, 16'($urandom), 4'($urandom), fa);
   endtask

   task automatic free_live();
      int idx;
      logic [47:0] off;
      idx = $urandom_range(live_offs.size() - 1);
      off = live_offs[idx];
      live_offs.delete(idx);
      free_addr(heap_base_now + off);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || sent_kind.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_base(logic [47:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      heap_base_now = v;
   endtask

   task automatic random_item();
      int r;
      logic [15:0] nb;
      logic [3:0] al;
      r = $urandom_range(99);
      if (r < 55 || live_offs.size() == 0 && r < 90) begin
         case ($urandom_range(9))
            7: nb = 16'($urandom_range(0, 63));
            8: nb = 16'($urandom);
            9: nb = 16'($urandom_range(2048, 4096));
            default: nb = 16'($urandom_range(64, 1500));
         endcase
         al = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4));
         alloc(nb, al);
      end else if (r < 90) begin
         free_live();
      end else if (r < 95) begin
         free_addr(48'({$urandom, $urandom}));
      end else begin
         free_addr(heap_base_now + 48'($urandom_range(0, 4095)));
      end
   endtask

   initial begin
      logic [47:0] bases[4];
      bases = '{48'd0, AMAX, 48'hFFFF_FFFF_F800, 48'({$urandom, $urandom})};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      set_base(48'h0000_1000_0000);

      // directed corners
      alloc(16'd0, 4'd0);
      alloc(16'hFFFF, 4'd0);
      alloc(16'd4096, 4'd0);
      alloc(16'd1, 4'd15);
      alloc(16'd100, 4'd3);
      alloc(16'd2000, 4'd0);
      alloc(16'd7, 4'd11);
      free_addr(AMAX);
      free_addr(heap_base_now + 48'd4096);
      drain();
      free_addr(heap_base_now + live_offs[0] + 48'd1);
      while (live_offs.size() > 0) free_live();
      free_addr(heap_base_now);
      alloc(16'd4096, 4'd0);
      drain();
      free_live();
      alloc(16'd2048, 4'd0);
      alloc(16'd1024, 4'd0);
      alloc(16'd1024, 4'd0);
      alloc(16'd1, 4'd0);

      for (int ph = 0; ph < 4; ph++) begin
         set_base(bases[ph]);
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 88; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 88; end
            default: begin send_idle = 31; recv_stall = 31; end
         endcase
         for (int n = 0; n < 150; n++) begin
            if (ph == 0 && n == 70) holds_asked = holds_asked + 1;
            if (ph == 2 && n == 75) drain();
            random_item();
         end
      end
      drain();

      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
